// ----- rtl/ssv_pkg.sv -----
package ssv_pkg;

    localparam int CUTOFF_ENTRIES = 256;
    localparam int CIDX_W = $clog2(CUTOFF_ENTRIES);
    // Cutoff index sum: 8-bit base plus a 9-bit signed modulation term.
    localparam int CSUM_W = 11;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_OSC_MIX     = 3'd1;
    localparam logic [2:0] CFG_CUTOFF_BASE = 3'd2;
    localparam logic [2:0] CFG_RESONANCE   = 3'd3;
    localparam logic [2:0] CFG_ENV_AMOUNT  = 3'd4;
    localparam logic [2:0] CFG_ENV_STEPS   = 3'd5;
    localparam logic [2:0] CFG_GLIDE_COEF  = 3'd6;
    localparam logic [2:0] CFG_OUT_GAIN    = 3'd7;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [1:0] WAVE_RAMP  = 2'd0;
    localparam logic [1:0] WAVE_PULSE = 2'd1;

    localparam logic [16:0] GLIDE_INSTANT = 17'd65536;
    localparam logic [16:0] DAMP_BASE     = 17'd124518;
    localparam logic [8:0]  DAMP_PER_RES  = 9'd462;
    localparam int          BP_CLAMP      = 262144;
    localparam int          SAMPLE_MAX    = 32767;
    localparam logic [14:0] ENV_MAX       = 15'h7fff;

    typedef enum logic [1:0] {
        ENV_IDLE   = 2'd0,
        ENV_ATTACK = 2'd1,
        ENV_DECAY  = 2'd2
    } t_env_stage;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ENV,
        S_GLIDE,
        S_WAVE_M,
        S_WAVE_T,
        S_TWIN_INC,
        S_CUT,
        S_COEF,
        S_DAMP,
        S_HP,
        S_BPM,
        S_BP,
        S_LPM,
        S_LP,
        S_AMP1,
        S_AMP2,
        S_AMP3,
        S_SAT,
        S_OUT
    } t_state;

    typedef logic [15:0] t_rom [CUTOFF_ENTRIES];

    // Coefficient table: 2*sin(pi*fc/fs2) by a cubic series, fc stepped by
    // 2^(1/32) from 40 Hz and capped at 8 kHz. Evaluated at elaboration.
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] fc;
        logic [63:0] a;
        logic [63:0] a3;
        logic [63:0] s;
        fc = 64'd2621440;
        for (int i = 0; i < CUTOFF_ENTRIES; i++) begin
            if (fc > 64'd524288000) begin
                fc = 64'd524288000;
            end
            a  = (fc * 64'd152983) >> 16;
            a3 = (((a * a) >> 32) * a) >> 32;
            s  = a - a3 / 64'd6;
            rom[i] = s[30:15];
            fc = (fc * 64'd4389014833) >> 32;
        end
        return rom;
    endfunction

    localparam t_rom CUTOFF_ROM = f_build_rom();

endpackage

// ----- rtl/subtractive_synth_voice.sv -----
// Channel | Direction | Handshake                   | Payload
// input   | in        | i_in_valid / o_in_stall     | i_op, i_note_inc
// output  | out       | o_out_valid / i_out_stall   | o_sample, o_voice_active
// config  | in        | i_cfg_we (no handshake)     | i_cfg_index, i_cfg_data
//
// Note-on, note-off and unused ops are absorbed in the cycle they are accepted.
// A tick on an active voice loads its result in the output step, and the next item
// is taken once the voice is back in idle: one 34x18 multiplier is shared by every
// product but the damping term, each product registered and used in the next state.
// A tick that leaves the voice idle goes from the envelope step to the output step.
// Reset is synchronous and active low; it needs no clearing pass.
// A stalled result holds in the output register; a finished tick waits for it.
module subtractive_synth_voice
    import ssv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_note_inc,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_voice_active,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_state r_state, n_state;

    logic [2:0]        r_mode;
    logic [15:0]       r_osc_mix;
    logic [7:0]        r_cutoff_base;
    logic [7:0]        r_resonance;
    logic signed [8:0] r_env_amount;
    logic [31:0]       r_env_steps;
    logic [16:0]       r_glide_coef;
    logic [9:0]        r_out_gain;

    logic [31:0]         r_main_phase, r_twin_phase, r_sub_phase;
    logic [31:0]         r_cur_inc, r_target_inc;
    logic [14:0]         r_env_level;
    t_env_stage          r_env_stage;
    logic                r_gate_on;
    logic [31:0]         r_lowpass;
    logic signed [19:0]  r_bandpass;

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [17:0]        r_mix;
    logic [CIDX_W-1:0]         r_cidx;
    logic [15:0]               r_f;
    logic [31:0]               r_hpw;
    logic signed [33:0]        r_bp;
    logic                      r_pass;
    logic signed [31:0]        r_y;
    logic signed [15:0]        r_res_sample;
    logic                      r_res_active;
    logic                      r_out_valid;
    logic signed [15:0]        r_sample;
    logic                      r_voice_active;

    logic        in_acc;
    logic        out_free;
    logic [1:0]  wave;
    logic [7:0]  detune;
    logic [7:0]  sub_lvl;
    logic [10:0] det;
    logic [16:0] damp;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign wave     = r_mode[1:0];
    assign detune   = r_osc_mix[7:0];
    assign sub_lvl  = r_osc_mix[15:8];
    assign det      = {detune, 3'b000};
    assign damp     = DAMP_BASE - ({9'd0, r_resonance} * {8'd0, DAMP_PER_RES});

    // Parabolic sine operands: signed triangle and the 32768 - |t| factor.
    function automatic logic signed [16:0] f_tri(input logic [31:0] phase);
        logic [14:0] t;
        t = phase[31:17];
        if (!t[14]) begin
            return $signed({2'b00, t} - 17'd16384) + $signed({2'b00, t});
        end
        return $signed(17'd49150 - {1'b0, t, 1'b0});
    endfunction

    function automatic logic [17:0] f_sine_fac(input logic signed [16:0] tri_v);
        logic [16:0] mag;
        mag = tri_v[16] ? 17'(-tri_v) : 17'(tri_v);
        return 18'd32768 - {1'b0, mag};
    endfunction

    // Saw or square value; the sine comes from the product.
    function automatic logic signed [17:0] f_wave(input logic [31:0] phase,
                                                  input logic [1:0] w,
                                                  input logic signed [PROD_W-1:0] prod);
        logic signed [16:0] saw;
        saw = $signed({2'b00, phase[31:17]} - 17'd16384) >>> 1;
        if (w == WAVE_RAMP) begin
            return 18'(saw);
        end
        if (w == WAVE_PULSE) begin
            return phase[31] ? -18'sd8192 : 18'sd8192;
        end
        return 18'($signed(prod[31:15]));
    endfunction

    logic signed [16:0] tri_main, tri_twin;
    logic signed [17:0] sub_term;
    logic signed [CSUM_W-1:0] csum;
    logic signed [33:0] bp_clamp;

    assign tri_main = f_tri(r_main_phase);
    assign tri_twin = f_tri(r_twin_phase);
    assign sub_term = r_sub_phase[31] ? -$signed({5'b0, sub_lvl, 5'b0})
                                      : $signed({5'b0, sub_lvl, 5'b0});
    assign csum = $signed({3'b000, r_cutoff_base}) + $signed(r_prod[25:15]);
    assign bp_clamp = (r_bp > 34'sd262144) ? 34'sd262144 :
                      (r_bp < -34'sd262144) ? -34'sd262144 : r_bp;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc && i_op == OP_TICK) n_state = S_ENV;
            S_ENV: begin
                n_state = S_GLIDE;
                if (r_env_stage == ENV_IDLE) begin
                    n_state = S_OUT;
                end else if (r_env_stage == ENV_ATTACK) begin
                    n_state = S_GLIDE;
                end else if (!(r_mode[2] && r_gate_on)
                             && {1'b0, r_env_level} <= r_env_steps[31:16]) begin
                    n_state = S_OUT;
                end
            end
            S_GLIDE:    n_state = S_WAVE_M;
            S_WAVE_M:   n_state = S_WAVE_T;
            S_WAVE_T:   n_state = S_TWIN_INC;
            S_TWIN_INC: n_state = S_CUT;
            S_CUT:      n_state = S_COEF;
            S_COEF:     n_state = S_DAMP;
            S_DAMP:     n_state = S_HP;
            S_HP:       n_state = S_BPM;
            S_BPM:      n_state = S_BP;
            S_BP:       n_state = S_LPM;
            S_LPM:      n_state = S_LP;
            S_LP:       n_state = r_pass ? S_AMP1 : S_DAMP;
            S_AMP1:     n_state = S_AMP2;
            S_AMP2:     n_state = S_AMP3;
            S_AMP3:     n_state = S_SAT;
            S_SAT:      n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_GLIDE: begin
                mul_a = 34'($signed(r_target_inc - r_cur_inc));
                mul_b = $signed({1'b0, r_glide_coef});
            end
            S_WAVE_M: begin
                mul_a = 34'(tri_main);
                mul_b = $signed(f_sine_fac(tri_main));
            end
            S_WAVE_T: begin
                mul_a = 34'(tri_twin);
                mul_b = $signed(f_sine_fac(tri_twin));
            end
            S_TWIN_INC: begin
                mul_a = $signed({2'b00, r_cur_inc});
                mul_b = $signed({7'b0, det});
            end
            S_CUT: begin
                mul_a = $signed({19'b0, r_env_level});
                mul_b = 18'(r_env_amount);
            end
            S_DAMP: begin
                mul_a = 34'(r_bandpass);
                mul_b = $signed({1'b0, damp});
            end
            S_BPM: begin
                mul_a = 34'($signed(r_hpw));
                mul_b = $signed({2'b00, r_f});
            end
            S_LPM: begin
                mul_a = r_bp;
                mul_b = $signed({2'b00, r_f});
            end
            S_AMP1: begin
                mul_a = 34'($signed(r_lowpass));
                mul_b = $signed({3'b000, r_env_level});
            end
            S_AMP3: begin
                mul_a = 34'(r_y);
                mul_b = $signed({8'b0, r_out_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= '0;
            r_osc_mix     <= '0;
            r_cutoff_base <= 8'd255;
            r_resonance   <= '0;
            r_env_amount  <= '0;
            r_env_steps   <= 32'd65537;
            r_glide_coef  <= GLIDE_INSTANT;
            r_out_gain    <= 10'd256;
            r_main_phase  <= '0;
            r_twin_phase  <= '0;
            r_sub_phase   <= '0;
            r_cur_inc     <= '0;
            r_target_inc  <= '0;
            r_env_level   <= '0;
            r_env_stage   <= ENV_IDLE;
            r_gate_on     <= 1'b0;
            r_lowpass     <= '0;
            r_bandpass    <= '0;
            r_pass        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:        r_mode        <= i_cfg_data[2:0];
                    CFG_OSC_MIX:     r_osc_mix     <= i_cfg_data[15:0];
                    CFG_CUTOFF_BASE: r_cutoff_base <= i_cfg_data[7:0];
                    CFG_RESONANCE:   r_resonance   <= i_cfg_data[7:0];
                    CFG_ENV_AMOUNT:  r_env_amount  <= $signed(i_cfg_data[8:0]);
                    CFG_ENV_STEPS:   r_env_steps   <= i_cfg_data;
                    CFG_GLIDE_COEF:  r_glide_coef  <= i_cfg_data[16:0];
                    CFG_OUT_GAIN:    r_out_gain    <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            // The output step reloads the register itself when it is free.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_op == OP_NOTE_ON) begin
                        r_target_inc <= i_note_inc;
                        if (r_env_stage == ENV_IDLE || r_glide_coef == GLIDE_INSTANT) begin
                            r_cur_inc <= i_note_inc;
                        end
                        r_gate_on   <= 1'b1;
                        r_env_stage <= ENV_ATTACK;
                    end else if (in_acc && i_op == OP_NOTE_OFF) begin
                        r_gate_on <= 1'b0;
                    end
                end
                S_ENV: begin
                    r_res_sample <= '0;
                    r_res_active <= 1'b0;
                    r_pass       <= 1'b0;
                    if (r_env_stage == ENV_ATTACK) begin
                        if ({2'b00, r_env_level} + {1'b0, r_env_steps[15:0]} >= 17'd32767) begin
                            r_env_level <= ENV_MAX;
                            r_env_stage <= ENV_DECAY;
                        end else begin
                            r_env_level <= 15'({2'b00, r_env_level}
                                               + {1'b0, r_env_steps[15:0]});
                        end
                    end else if (r_env_stage != ENV_IDLE && !(r_mode[2] && r_gate_on)) begin
                        if ({1'b0, r_env_level} <= r_env_steps[31:16]) begin
                            r_env_level <= '0;
                            r_env_stage <= ENV_IDLE;
                        end else begin
                            r_env_level <= r_env_level - r_env_steps[30:16];
                        end
                    end
                end
                S_WAVE_M: r_cur_inc <= r_cur_inc + r_prod[47:16];
                S_WAVE_T: r_mix <= f_wave(r_main_phase, wave, r_prod);
                S_TWIN_INC: begin
                    r_mix <= r_mix + sub_term
                           + ((detune != 8'd0) ? f_wave(r_twin_phase, wave, r_prod) : 18'sd0);
                    r_main_phase <= r_main_phase + r_cur_inc;
                    r_sub_phase  <= r_sub_phase + {1'b0, r_cur_inc[31:1]};
                end
                S_CUT: r_twin_phase <= r_twin_phase + r_cur_inc + r_prod[47:16];
                S_COEF: begin
                    if (csum < 0) begin
                        r_cidx <= '0;
                    end else if (csum > CSUM_W'(CUTOFF_ENTRIES - 1)) begin
                        r_cidx <= CIDX_W'(CUTOFF_ENTRIES - 1);
                    end else begin
                        r_cidx <= csum[CIDX_W-1:0];
                    end
                end
                S_DAMP: r_f <= CUTOFF_ROM[r_cidx];
                S_HP: r_hpw <= 32'(r_mix) - r_lowpass - r_prod[47:16];
                S_BP: r_bp <= 34'(r_bandpass) + $signed(r_prod[49:16]);
                S_LP: begin
                    r_lowpass  <= r_lowpass + r_prod[47:16];
                    r_bandpass <= bp_clamp[19:0];
                    r_pass     <= 1'b1;
                end
                S_AMP2: r_y <= $signed(r_prod[46:15]);
                S_SAT: begin
                    r_res_active <= 1'b1;
                    if ($signed(r_prod[42:8]) > 35'sd32767) begin
                        r_res_sample <= 16'sd32767;
                    end else if ($signed(r_prod[42:8]) < -35'sd32767) begin
                        r_res_sample <= -16'sd32767;
                    end else begin
                        r_res_sample <= $signed(r_prod[23:8]);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_sample       <= r_res_sample;
                        r_voice_active <= r_res_active;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_voice_active = r_voice_active;

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result appeared outside the output step");

    a_bp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bandpass <= 20'sd262144 && r_bandpass >= -20'sd262144)
        else $error("bandpass accumulator out of clamp range");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_voice_active |-> o_sample == 16'sd0)
        else $error("idle result carries a nonzero sample");

endmodule

// ----- bench/tb_subtractive_synth_voice.sv -----
`timescale 1ns / 1ps

module tb_subtractive_synth_voice
    import ssv_pkg::*;
;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_op;
    logic [31:0]        i_note_inc;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_sample;
    logic               o_voice_active;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    subtractive_synth_voice i_dut (.*);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
    } t_voice_out;

    // Model copy of the voice.
    logic [2:0]  m_mode;
    logic [15:0] m_osc_mix;
    logic [7:0]  m_cutoff_base;
    logic [7:0]  m_resonance;
    logic [8:0]  m_env_amount;
    logic [31:0] m_env_steps;
    logic [16:0] m_glide;
    logic [9:0]  m_gain;
    logic [31:0] m_main_ph, m_twin_ph, m_sub_ph, m_cur_inc, m_tgt_inc;
    int          m_env;
    t_env_stage  m_stage;
    logic        m_gate;
    logic [31:0] m_lp;
    longint      m_bp;
    logic [15:0] m_rom [CUTOFF_ENTRIES];

    t_voice_out  sample_queue[$];
    int          n_fail;
    int          in_idle_pct;
    int          out_stall_pct;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint sx32(logic [31:0] x);
        return longint'(signed'(x));
    endfunction

    task automatic build_rom();
        logic [63:0] fc, a, a3, s;
        fc = 64'd2621440;
        for (int i = 0; i < CUTOFF_ENTRIES; i++) begin
            if (fc > 64'd524288000) fc = 64'd524288000;
            a  = (fc * 64'd152983) >> 16;
            a3 = (((a * a) >> 32) * a) >> 32;
            s  = a - a3 / 64'd6;
            m_rom[i] = s[30:15];
            fc = (fc * 64'd4389014833) >> 32;
        end
    endtask

    function automatic longint wave_of(logic [31:0] ph, logic [1:0] w);
        longint t, a;
        t = longint'(ph[31:17]);
        if (w == WAVE_RAMP) return fshr(t - 16384, 1);
        if (w == WAVE_PULSE) return ph[31] ? -8192 : 8192;
        t = (t < 16384) ? t * 2 - 16384 : 49150 - t * 2;
        a = t < 0 ? -t : t;
        return fshr(t * (32768 - a), 15);
    endfunction

    task automatic model_reset();
        m_mode = 0; m_osc_mix = 0; m_cutoff_base = 255; m_resonance = 0;
        m_env_amount = 0; m_env_steps = 32'd65537; m_glide = GLIDE_INSTANT; m_gain = 256;
        m_main_ph = 0; m_twin_ph = 0; m_sub_ph = 0; m_cur_inc = 0; m_tgt_inc = 0;
        m_env = 0; m_stage = ENV_IDLE; m_gate = 0; m_lp = 0; m_bp = 0;
    endtask

    task automatic predict_voice(logic [1:0] op, logic [31:0] inc);
        longint mix, y, damp, amt, c, f, bp;
        logic [31:0] det, hpw;
        logic [7:0] sub;
        t_voice_out r;
        if (op == OP_NOTE_ON) begin
            m_tgt_inc = inc;
            if (m_stage == ENV_IDLE || m_glide == GLIDE_INSTANT) m_cur_inc = inc;
            m_gate = 1;
            m_stage = ENV_ATTACK;
            return;
        end
        if (op == OP_NOTE_OFF) begin
            m_gate = 0;
            return;
        end
        if (op != OP_TICK) return;
        if (m_stage == ENV_ATTACK) begin
            m_env += int'(m_env_steps[15:0]);
            if (m_env >= 32767) begin
                m_env = 32767;
                m_stage = ENV_DECAY;
            end
        end else if (m_stage != ENV_IDLE) begin
            if (!(m_mode[2] && m_gate)) begin
                m_env -= int'(m_env_steps[31:16]);
                if (m_env <= 0) begin
                    m_env = 0;
                    m_stage = ENV_IDLE;
                end
            end
        end
        if (m_stage == ENV_IDLE) begin
            r.sample = 0;
            r.active = 0;
            sample_queue.push_back(r);
            return;
        end
        m_cur_inc += 32'(fshr(sx32(m_tgt_inc - m_cur_inc) * longint'(m_glide), 16));
        sub = m_osc_mix[15:8];
        det = {21'd0, m_osc_mix[7:0], 3'd0};
        mix = wave_of(m_main_ph, m_mode[1:0]);
        if (m_osc_mix[7:0] != 0) mix += wave_of(m_twin_ph, m_mode[1:0]);
        if (sub != 0) mix += fshr((m_sub_ph[31] ? -8192 : 8192) * longint'(sub), 8);
        m_main_ph += m_cur_inc;
        m_twin_ph += m_cur_inc + 32'((longint'(m_cur_inc) * longint'(det)) >> 16);
        m_sub_ph += m_cur_inc >> 1;
        amt = longint'(signed'(m_env_amount));
        c = longint'(m_cutoff_base) + fshr(longint'(m_env) * amt, 15);
        if (c < 0) c = 0;
        if (c > CUTOFF_ENTRIES - 1) c = CUTOFF_ENTRIES - 1;
        f = longint'(m_rom[c]);
        damp = 124518 - longint'(m_resonance) * 462;
        for (int k = 0; k < 2; k++) begin
            hpw = 32'(mix) - m_lp - 32'(fshr(m_bp * damp, 16));
            bp = m_bp + fshr(f * sx32(hpw), 16);
            m_lp += 32'(fshr(f * bp, 16));
            if (bp > BP_CLAMP) bp = BP_CLAMP;
            else if (bp < -BP_CLAMP) bp = -BP_CLAMP;
            m_bp = bp;
        end
        y = fshr(sx32(m_lp) * longint'(m_env), 15);
        y = fshr(y * longint'(m_gain), 8);
        if (y > SAMPLE_MAX) y = SAMPLE_MAX;
        else if (y < -SAMPLE_MAX) y = -SAMPLE_MAX;
        r.sample = 16'(y);
        r.active = 1;
        sample_queue.push_back(r);
    endtask

    // Receiver: random stall and comparison of every accepted result.
    always @(posedge i_clk) begin
        t_voice_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sample_queue.size() == 0) begin
                $display("%0t: unexpected result sample=%0d active=%0b",
                         $time, o_sample, o_voice_active);
                n_fail++;
            end else begin
                e = sample_queue.pop_front();
                if (o_sample !== e.sample) begin
                    $display("%0t: sample expected %0d actual %0d", $time, e.sample, o_sample);
                    n_fail++;
                end
                if (o_voice_active !== e.active) begin
                    $display("%0t: voice_active expected %0b actual %0b",
                             $time, e.active, o_voice_active);
                    n_fail++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // The valid stays up after acceptance until the next item or a drain drops it.
    task automatic send_item(logic [1:0] op, logic [31:0] inc);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_note_inc <= inc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_voice(op, inc);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sample_queue.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    // The write enable stays up until the next item is sent.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:        m_mode = val[2:0];
            CFG_OSC_MIX:     m_osc_mix = val[15:0];
            CFG_CUTOFF_BASE: m_cutoff_base = val[7:0];
            CFG_RESONANCE:   m_resonance = val[7:0];
            CFG_ENV_AMOUNT:  m_env_amount = val[8:0];
            CFG_ENV_STEPS:   m_env_steps = val;
            CFG_GLIDE_COEF:  m_glide = val[16:0];
            default:         m_gain = val[9:0];
        endcase
    endtask

    task automatic random_config(bit extreme);
        if (extreme) begin
            write_reg(CFG_MODE, $urandom_range(7));
            write_reg(CFG_OSC_MIX, $urandom_range(1) ? 32'hffff : 32'h0);
            write_reg(CFG_CUTOFF_BASE, $urandom_range(1) ? 255 : 0);
            write_reg(CFG_RESONANCE, $urandom_range(1) ? 255 : 0);
            write_reg(CFG_ENV_AMOUNT, $urandom_range(1) ? 9'h0ff : 9'h101);
            write_reg(CFG_ENV_STEPS, $urandom_range(1) ? 32'hffffffff : 32'h00010001);
            write_reg(CFG_GLIDE_COEF, $urandom_range(1) ? 65536 : 1);
            write_reg(CFG_OUT_GAIN, $urandom_range(1) ? 1023 : 0);
        end else begin
            write_reg(CFG_MODE, $urandom_range(7));
            write_reg(CFG_OSC_MIX, $urandom);
            write_reg(CFG_CUTOFF_BASE, $urandom_range(255));
            write_reg(CFG_RESONANCE, $urandom_range(255));
            write_reg(CFG_ENV_AMOUNT, $urandom_range(510) - 255);
            // Steps small enough that attack and decay last a while.
            write_reg(CFG_ENV_STEPS, {16'($urandom_range(1, 3000)), 16'($urandom_range(1, 8000))});
            write_reg(CFG_GLIDE_COEF, $urandom_range(1) ? $urandom_range(1, 65536)
                                                         : $urandom_range(131071));
            write_reg(CFG_OUT_GAIN, $urandom_range(1023));
        end
    endtask

    task automatic test_directed();
        write_reg(CFG_MODE, 0);
        send_item(OP_TICK, 0);
        send_item(2'd3, 32'hffffffff);
        send_item(OP_NOTE_OFF, 0);
        send_item(OP_NOTE_ON, 32'hffffffff);
        repeat (3) send_item(OP_TICK, 0);
        send_item(OP_NOTE_ON, 32'h0);
        send_item(OP_TICK, 0);
        drain();
        write_reg(CFG_MODE, 7);
        write_reg(CFG_OSC_MIX, 32'hffff);
        write_reg(CFG_ENV_STEPS, 32'hffffffff);
        write_reg(CFG_GLIDE_COEF, 1);
        write_reg(CFG_OUT_GAIN, 1023);
        write_reg(CFG_RESONANCE, 255);
        write_reg(CFG_ENV_AMOUNT, 9'h101);
        write_reg(CFG_CUTOFF_BASE, 0);
        send_item(OP_NOTE_ON, 32'h7fffffff);
        repeat (3) send_item(OP_TICK, 0);
        send_item(OP_NOTE_ON, 32'h80000000);
        send_item(OP_TICK, 0);
        send_item(OP_NOTE_OFF, 0);
        repeat (3) send_item(OP_TICK, 0);
        drain();
        write_reg(CFG_GLIDE_COEF, 0);
        write_reg(CFG_ENV_AMOUNT, 9'h0ff);
        write_reg(CFG_CUTOFF_BASE, 255);
        write_reg(CFG_MODE, 2);
        send_item(OP_NOTE_ON, 32'h12345678);
        repeat (4) send_item(OP_TICK, 0);
        drain();
    endtask

    task automatic test_random(int phase_items, bit extreme);
        int r;
        random_config(extreme);
        for (int n = 0; n < phase_items; n++) begin
            r = $urandom_range(99);
            if (r < 6) send_item(OP_NOTE_ON, $urandom);
            else if (r < 9) send_item(OP_NOTE_OFF, $urandom);
            else if (r < 10) send_item(2'd3, $urandom);
            else send_item(OP_TICK, $urandom);
        end
        drain();
    endtask

    task automatic test_idle_phases();
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 85; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 85; end
                default: begin in_idle_pct = 18; out_stall_pct = 18; end
            endcase
            test_random(175, p == 3 || p == 6);
        end
    endtask

    initial begin
        n_fail = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_TICK;
        i_note_inc = 0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = 0;
        build_rom();
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_idle_phases();
        if (sample_queue.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sample_queue.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ssv_pkg.sv
rtl/subtractive_synth_voice.sv
bench/tb_subtractive_synth_voice.sv
